FILE: src/srm_pkg.sv
package srm_pkg;

    localparam int REGISTER_COUNT = 6;
    localparam int REG_IDX_W      = 3;
    localparam int WORD_W         = 32;
    localparam int LEN_W          = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int Q_DEPTH        = 2;
    localparam int Q_PTR_W        = 1;

    typedef enum logic [3:0] {
        OP_ADDR = 4'd0,
        OP_ADDI = 4'd1,
        OP_MULR = 4'd2,
        OP_MULI = 4'd3,
        OP_BANR = 4'd4,
        OP_BANI = 4'd5,
        OP_BORR = 4'd6,
        OP_BORI = 4'd7,
        OP_SETR = 4'd8,
        OP_SETI = 4'd9,
        OP_GTIR = 4'd10,
        OP_GTRI = 4'd11,
        OP_GTRR = 4'd12,
        OP_EQIR = 4'd13,
        OP_EQRI = 4'd14,
        OP_EQRR = 4'd15
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POINTER_REGISTER = 2'd0,
        CFG_PROGRAM_LENGTH   = 2'd1
    } t_cfg_idx;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [REG_IDX_W-1:0]     t_ridx;

    typedef struct packed {
        logic [3:0] op_code;
        t_word      operand_a;
        t_word      operand_b;
        t_word      operand_c;
    } t_in_req;

    typedef struct packed {
        t_word      next_ip;
        logic       halted;
        logic       fault;
        t_word      written_value;
        t_word      first_register;
    } t_out_req;

    // classified instruction handed from front to back
    typedef struct packed {
        t_op   op;
        t_word imm_a;
        t_word imm_b;
        t_ridx a_idx;
        t_ridx b_idx;
        t_ridx c_idx;
        logic  fault;
    } t_dec;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic idx_ok(input t_word x);
        return (x >= 0) && (x < t_word'(REGISTER_COUNT));
    endfunction

endpackage

FILE: src/srm_front.sv
module srm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  srm_pkg::t_in_req  i_in_req,
    input  srm_pkg::t_q_status i_q_status,
    output logic              o_push,
    output srm_pkg::t_dec     o_push_data
);
    import srm_pkg::*;

    logic  r_valid;
    t_dec  r_dec;
    t_dec  n_dec;
    logic  a_reg;
    logic  b_reg;
    logic  accept;
    t_op   op;

    assign op = t_op'(i_in_req.op_code);

    // which operands name registers
    always_comb begin
        a_reg = 1'b0;
        b_reg = 1'b0;
        case (op)
            OP_ADDR, OP_MULR, OP_BANR, OP_BORR, OP_GTRR, OP_EQRR: begin
                a_reg = 1'b1;
                b_reg = 1'b1;
            end
            OP_ADDI, OP_MULI, OP_BANI, OP_BORI, OP_SETR, OP_GTRI, OP_EQRI: begin
                a_reg = 1'b1;
            end
            OP_GTIR, OP_EQIR: begin
                b_reg = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_dec.op    = op;
        n_dec.imm_a = i_in_req.operand_a;
        n_dec.imm_b = i_in_req.operand_b;
        n_dec.a_idx = i_in_req.operand_a[REG_IDX_W-1:0];
        n_dec.b_idx = i_in_req.operand_b[REG_IDX_W-1:0];
        n_dec.c_idx = i_in_req.operand_c[REG_IDX_W-1:0];
        n_dec.fault = !idx_ok(i_in_req.operand_c)
                    || (a_reg && !idx_ok(i_in_req.operand_a))
                    || (b_reg && !idx_ok(i_in_req.operand_b));
    end

    assign o_push      = r_valid && !i_q_status.full;
    assign o_push_data = r_dec;
    assign o_in_stall  = r_valid && i_q_status.full;
    assign accept      = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dec <= n_dec;
        end
    end

endmodule

FILE: src/srm_queue.sv
module srm_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  srm_pkg::t_dec      i_push_data,
    input  logic               i_pop,
    output srm_pkg::t_dec      o_pop_data,
    output srm_pkg::t_q_status o_status
);
    import srm_pkg::*;

    t_dec                r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_PTR_W:0]    r_count;

    assign o_status.full  = (r_count == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_pop_data     = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

FILE: src/srm_back.sv
module srm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [2:0]         i_pointer_register,
    input  logic [15:0]        i_program_length,
    input  srm_pkg::t_q_status i_q_status,
    input  srm_pkg::t_dec      i_pop_data,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output srm_pkg::t_out_req  o_out_req
);
    import srm_pkg::*;

    t_word    r_rf [REGISTER_COUNT];
    t_word    n_rf [REGISTER_COUNT];
    t_word    eff  [REGISTER_COUNT];
    t_word    r_ptr;
    t_word    n_ptr;
    logic     r_out_valid;
    t_out_req r_out;
    t_out_req n_out;
    logic     bound;
    logic     running;
    logic     n_in_prog;
    t_word    ra;
    t_word    rb;
    t_word    value;
    t_word    pr_final;
    t_dec     d;

    assign d     = i_pop_data;
    assign bound = (i_pointer_register < REG_IDX_W'(REGISTER_COUNT));
    assign o_pop = !i_q_status.empty && (!r_out_valid || !i_out_stall);

    assign running = !r_ptr[WORD_W-1]
                   && (r_ptr < t_word'({1'b0, i_program_length}));

    // register view with the pointer mirrored in
    always_comb begin
        for (int i = 0; i < REGISTER_COUNT; i++) begin
            eff[i] = (bound && i_pointer_register == REG_IDX_W'(i)) ? r_ptr : r_rf[i];
        end
    end

    always_comb begin
        ra = '0;
        rb = '0;
        for (int i = 0; i < REGISTER_COUNT; i++) begin
            if (d.a_idx == REG_IDX_W'(i)) begin
                ra = eff[i];
            end
            if (d.b_idx == REG_IDX_W'(i)) begin
                rb = eff[i];
            end
        end
    end

    always_comb begin
        case (d.op)
            OP_ADDR: value = ra + rb;
            OP_ADDI: value = ra + d.imm_b;
            OP_MULR: value = ra * rb;
            OP_MULI: value = ra * d.imm_b;
            OP_BANR: value = ra & rb;
            OP_BANI: value = ra & d.imm_b;
            OP_BORR: value = ra | rb;
            OP_BORI: value = ra | d.imm_b;
            OP_SETR: value = ra;
            OP_SETI: value = d.imm_a;
            OP_GTIR: value = t_word'(d.imm_a > rb);
            OP_GTRI: value = t_word'(ra > d.imm_b);
            OP_GTRR: value = t_word'(ra > rb);
            OP_EQIR: value = t_word'(d.imm_a == rb);
            OP_EQRI: value = t_word'(ra == d.imm_b);
            OP_EQRR: value = t_word'(ra == rb);
            default: value = '0;
        endcase
    end

    // register file after the step
    always_comb begin
        for (int i = 0; i < REGISTER_COUNT; i++) begin
            if (d.fault) begin
                n_rf[i] = (i == 0) ? '1 : eff[i];
            end else begin
                n_rf[i] = (d.c_idx == REG_IDX_W'(i)) ? value : eff[i];
            end
        end
    end

    always_comb begin
        pr_final = '0;
        for (int i = 0; i < REGISTER_COUNT; i++) begin
            if (i_pointer_register == REG_IDX_W'(i)) begin
                pr_final = n_rf[i];
            end
        end
    end

    assign n_ptr     = bound ? pr_final + 1'b1 : r_ptr + 1'b1;
    assign n_in_prog = !n_ptr[WORD_W-1]
                     && (n_ptr < t_word'({1'b0, i_program_length}));

    always_comb begin
        if (running) begin
            n_out.next_ip        = n_ptr;
            n_out.halted         = !n_in_prog;
            n_out.fault          = d.fault;
            n_out.written_value  = d.fault ? '1 : value;
            n_out.first_register = n_rf[0];
        end else begin
            n_out.next_ip        = r_ptr;
            n_out.halted         = 1'b1;
            n_out.fault          = 1'b0;
            n_out.written_value  = '0;
            n_out.first_register = r_rf[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_ptr       <= '0;
            for (int i = 0; i < REGISTER_COUNT; i++) begin
                r_rf[i] <= '0;
            end
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop && running) begin
                r_ptr <= n_ptr;
                for (int i = 0; i < REGISTER_COUNT; i++) begin
                    r_rf[i] <= n_rf[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule

FILE: src/six_register_machine_step.sv
// channel   direction  handshake               payload
// in        input      i_in_valid / o_in_stall  i_in_req  (t_in_req)
// out       output     o_out_valid / i_out_stall o_out_req (t_out_req)
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one instruction per cycle sustained while the output does not stall; the back executes the register read, alu
// and register write of a step in the same cycle, which sets the rate
// a request passes through the front register, the queue and the output register
// synchronous active-low reset clears the registers, pointer and configuration
// a two-entry queue lets the front keep taking requests while the output stalls, until the queue is full
module six_register_machine_step (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  srm_pkg::t_in_req            i_in_req,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output srm_pkg::t_out_req           o_out_req,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [srm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [srm_pkg::LEN_W-1:0]   i_cfg_data
);
    import srm_pkg::*;

    // configuration registers
    logic [REG_IDX_W-1:0] r_pointer_register;
    logic [LEN_W-1:0]     r_program_length;

    // front to queue
    logic      push;
    t_dec      push_data;
    // queue to back
    logic      pop;
    t_dec      pop_data;
    t_q_status q_status;

    // configuration is always accepted; it must only arrive while the block is idle, which the block does not enforce
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pointer_register <= '0;
            r_program_length   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_POINTER_REGISTER: r_pointer_register <= i_cfg_data[REG_IDX_W-1:0];
                CFG_PROGRAM_LENGTH:   r_program_length   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front: takes requests and classifies operands, flags bad register indexes
    srm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // short queue decouples the two halves
    srm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_status    (q_status)
    );

    // back: register file, pointer, alu and output register
    srm_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_pointer_register (r_pointer_register),
        .i_program_length   (r_program_length),
        .i_q_status         (q_status),
        .i_pop_data         (pop_data),
        .o_pop              (pop),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_req          (o_out_req)
    );

endmodule

FILE: tb/tb_six_register_machine_step.sv
module tb_six_register_machine_step;

    timeunit 1ns;
    timeprecision 1ps;

    import srm_pkg::*;

    // codes the block ignores on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // executed instructions wanted from the random part
    localparam int RUN_TARGET = 650;
    // keeps the pointer where a later program length can still reach it
    localparam int IP_CEILING = 60000;
    localparam int REPORT_LIMIT = 10;

    typedef enum int {
        STALL_NONE,
        STALL_SPARSE,
        STALL_PERIODIC,
        STALL_LONG
    } t_stall_mode;

    // ------------------------------------------------------------------
    // machine tracker: own copy of the register file, pointer and
    // configuration; every accepted request is executed here and the step
    // it must produce waits in expected_steps
    // ------------------------------------------------------------------
    class machine_tracker;
        t_word          regs [REGISTER_COUNT];
        t_word          ip;
        logic [2:0]     ptr_sel;
        logic [15:0]    prog_len;
        t_out_req       expected_steps [$];
        int             mismatches;

        function new();
            foreach (regs[i]) regs[i] = '0;
            ip = '0;
            ptr_sel = '0;
            prog_len = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
            case (idx)
                CFG_POINTER_REGISTER: ptr_sel = data[2:0];
                CFG_PROGRAM_LENGTH:   prog_len = data;
                default: ;
            endcase
        endfunction

        function bit in_program(t_word p);
            return (p >= 0) && (p < $signed({16'd0, prog_len}));
        endfunction

        function bit running();
            return in_program(ip);
        endfunction

        function bit is_index(t_word x);
            return (x >= 0) && (x < REGISTER_COUNT);
        endfunction

        function t_out_req execute(t_in_req req);
            t_out_req res;
            t_word    a, b, c, ra, rb, val;
            bit       bound, a_reg, b_reg, flt;
            res = '0;
            a = req.operand_a;
            b = req.operand_b;
            c = req.operand_c;
            ra = '0;
            rb = '0;
            val = '0;
            a_reg = 1'b0;
            b_reg = 1'b0;
            // halted machine: request ignored, nothing changes
            if (!running()) begin
                res.next_ip = ip;
                res.halted = 1'b1;
                res.first_register = regs[0];
                return res;
            end
            // pointer register 6 or 7 binds nothing
            bound = (ptr_sel < REGISTER_COUNT);
            if (bound) regs[ptr_sel] = ip;
            case (req.op_code)
                OP_ADDR, OP_MULR, OP_BANR, OP_BORR, OP_GTRR, OP_EQRR: begin
                    a_reg = 1'b1;
                    b_reg = 1'b1;
                end
                OP_ADDI, OP_MULI, OP_BANI, OP_BORI, OP_SETR, OP_GTRI, OP_EQRI: begin
                    a_reg = 1'b1;
                end
                OP_GTIR, OP_EQIR: begin
                    b_reg = 1'b1;
                end
                default: ;
            endcase
            // only register operands are range checked, never immediates
            flt = !is_index(c) || (a_reg && !is_index(a)) || (b_reg && !is_index(b));
            if (flt) begin
                regs[0] = -1;
                val = -1;
            end else begin
                if (a_reg) ra = regs[a[2:0]];
                if (b_reg) rb = regs[b[2:0]];
                case (req.op_code)
                    OP_ADDR: val = ra + rb;
                    OP_ADDI: val = ra + b;
                    OP_MULR: val = ra * rb;
                    OP_MULI: val = ra * b;
                    OP_BANR: val = ra & rb;
                    OP_BANI: val = ra & b;
                    OP_BORR: val = ra | rb;
                    OP_BORI: val = ra | b;
                    OP_SETR: val = ra;
                    OP_SETI: val = a;
                    OP_GTIR: val = (a > rb) ? 1 : 0;
                    OP_GTRI: val = (ra > b) ? 1 : 0;
                    OP_GTRR: val = (ra > rb) ? 1 : 0;
                    OP_EQIR: val = (a == rb) ? 1 : 0;
                    OP_EQRI: val = (ra == b) ? 1 : 0;
                    default: val = (ra == rb) ? 1 : 0;
                endcase
                regs[c[2:0]] = val;
            end
            if (bound) ip = regs[ptr_sel] + 1;
            else ip = ip + 1;
            res.next_ip = ip;
            res.halted = !in_program(ip);
            res.fault = flt;
            res.written_value = val;
            res.first_register = regs[0];
            return res;
        endfunction

        // where the pointer would land, state left untouched
        function t_word peek_next_ip(t_in_req req);
            t_word    keep_regs [REGISTER_COUNT];
            t_word    keep_ip;
            t_out_req res;
            keep_regs = regs;
            keep_ip = ip;
            res = execute(req);
            regs = keep_regs;
            ip = keep_ip;
            return res.next_ip;
        endfunction

        function void take_instr(t_in_req req);
            expected_steps = {expected_steps, execute(req)};
        endfunction

        function void check_step(t_out_req got);
            t_out_req want;
            if (expected_steps.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: stray step ip=%0d h=%0b f=%0b wr=%0d r0=%0d",
                             $realtime, got.next_ip, got.halted, got.fault,
                             got.written_value, got.first_register);
                return;
            end
            want = expected_steps.pop_front();
            if (got.next_ip !== want.next_ip || got.halted !== want.halted ||
                got.fault !== want.fault || got.written_value !== want.written_value ||
                got.first_register !== want.first_register) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t: step differs, want ip=%0d h=%0b f=%0b wr=%0d r0=%0d",
                             $realtime, want.next_ip, want.halted, want.fault,
                             want.written_value, want.first_register);
                    $display("%0t: step differs, got  ip=%0d h=%0b f=%0b wr=%0d r0=%0d",
                             $realtime, got.next_ip, got.halted, got.fault,
                             got.written_value, got.first_register);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    t_in_req                i_in_req = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    t_out_req               o_out_req;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [LEN_W-1:0]       i_cfg_data = '0;

    machine_tracker sb;

    // sender burst state
    int burst_left = 0;

    // receiver stall pattern state
    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left = 0;
    int          hold_left = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    six_register_machine_step uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // request building
    // ------------------------------------------------------------------
    function automatic t_in_req mk_instr(t_op op, t_word a, t_word b, t_word c);
        t_in_req req;
        req.op_code = op;
        req.operand_a = a;
        req.operand_b = b;
        req.operand_c = c;
        return req;
    endfunction

    // mostly register indexes, then small immediates, then anything
    function automatic t_word pick_operand();
        int r = $urandom_range(0, 99);
        if (r < 60) return t_word'($urandom_range(0, REGISTER_COUNT - 1));
        if (r < 80) return t_word'($urandom_range(0, 40));
        if (r < 90) return t_word'($urandom);
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return -1;
            3: return REGISTER_COUNT;
            default: return t_word'($urandom_range(REGISTER_COUNT, 255));
        endcase
    endfunction

    function automatic t_in_req random_instr();
        t_in_req req;
        req.op_code = 4'($urandom_range(0, 15));
        req.operand_a = pick_operand();
        req.operand_b = pick_operand();
        // destination is a legal register most of the time
        if ($urandom_range(0, 99) < 92)
            req.operand_c = t_word'($urandom_range(0, REGISTER_COUNT - 1));
        else
            req.operand_c = pick_operand();
        return req;
    endfunction

    // random instruction that never strands the pointer for good
    function automatic t_in_req safe_instr();
        t_in_req req;
        t_word   nip;
        for (int tries = 0; tries < 20; tries++) begin
            req = random_instr();
            nip = sb.peek_next_ip(req);
            if (nip >= 0 && nip < IP_CEILING) return req;
        end
        // plain fall-through: clear a register that is not the pointer
        return mk_instr(OP_SETI, 0, 0, (sb.ptr_sel == 0) ? 1 : 0);
    endfunction

    // ------------------------------------------------------------------
    // driving tasks, always entered right after a rising edge
    // ------------------------------------------------------------------
    task automatic push_instr(input t_in_req req);
        i_in_valid <= 1'b1;
        i_in_req <= req;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_instr(req);
    endtask

    // idle gap between bursts of requests
    task automatic pace();
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 5) == 0) ? 12 : 3))
                @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait for every outstanding step, then let the pipeline settle
    task automatic drain();
        while (sb.expected_steps.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // receiver: checks accepted steps and stalls on its own pattern
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_step(o_out_req);
        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (stall_mode)
            STALL_NONE:     i_out_stall <= 1'b0;
            STALL_SPARSE:   i_out_stall <= ($urandom_range(0, 3) == 0);
            // stall unless the mode counter is a multiple of four
            STALL_PERIODIC: i_out_stall <= (mode_left % 4 != 0);
            default: begin
                if (hold_left == 0 && $urandom_range(0, 5) == 0)
                    hold_left = $urandom_range(1, 8);
                if (hold_left > 0) begin
                    hold_left--;
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    t_in_req    directed [$];
    logic [2:0] first_ptrs [4] = '{3'd7, 3'd0, 3'd6, 3'd5};

    function automatic void add_directed(t_in_req req);
        directed = {directed, req};
    endfunction

    initial begin
        int          executed;
        int          idle_items;
        int          phase;
        int          n;
        int          r;
        int          base;
        logic [2:0]  psel;
        logic [15:0] plen;
        int          fails;

        sb = new();
        executed = 0;
        phase = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // program length is zero out of reset: the request is ignored
        push_instr(mk_instr(OP_ADDI, 0, 5, 1));
        i_in_valid <= 1'b0;
        drain();

        write_cfg(CFG_PROGRAM_LENGTH, 16'hFFFF);
        write_cfg(CFG_POINTER_REGISTER, 16'd5);

        // every opcode, word extremes, wrap, signed compares, faults
        add_directed(mk_instr(OP_SETI, 32'h7FFF_FFFF, 0, 1));
        add_directed(mk_instr(OP_SETI, 32'h8000_0000, -1, 2));
        add_directed(mk_instr(OP_ADDR, 1, 1, 3));
        add_directed(mk_instr(OP_ADDI, 2, -1, 3));
        add_directed(mk_instr(OP_MULR, 1, 1, 4));
        add_directed(mk_instr(OP_MULI, 1, 32'h8000_0001, 4));
        add_directed(mk_instr(OP_BANR, 1, 2, 0));
        add_directed(mk_instr(OP_BANI, 2, 32'hFFFF_FFFF, 0));
        add_directed(mk_instr(OP_BORR, 1, 2, 3));
        add_directed(mk_instr(OP_BORI, 0, 32'h5A5A_5A5A, 0));
        // reads the register that mirrors the pointer
        add_directed(mk_instr(OP_SETR, 5, -1, 4));
        add_directed(mk_instr(OP_GTIR, -1, 2, 3));
        add_directed(mk_instr(OP_GTRI, 2, 0, 3));
        add_directed(mk_instr(OP_GTRR, 1, 2, 3));
        add_directed(mk_instr(OP_EQIR, 32'h8000_0000, 2, 0));
        add_directed(mk_instr(OP_EQRI, 1, 32'h7FFF_FFFF, 0));
        add_directed(mk_instr(OP_EQRR, 4, 4, 0));
        // register operand out of range
        add_directed(mk_instr(OP_ADDR, 6, 0, 1));
        // immediate a is never checked, register b is
        add_directed(mk_instr(OP_GTIR, 99, -1, 1));
        // destination out of range
        add_directed(mk_instr(OP_SETI, 0, 0, 32'h8000_0000));
        // unused operand with any value is fine
        add_directed(mk_instr(OP_SETI, 123, 32'hFFFF_FFFF, 2));
        // jumps through the pointer register
        add_directed(mk_instr(OP_ADDI, 5, 2, 5));
        add_directed(mk_instr(OP_SETI, 3, 0, 5));

        burst_left = $urandom_range(1, 8);
        foreach (directed[i]) begin
            if (i != 0) pace();
            push_instr(directed[i]);
        end
        i_in_valid <= 1'b0;
        drain();

        // random phases: new settings, then a run of fetched instructions
        while (executed < RUN_TARGET) begin
            // pointer register: fixed extremes first, then anything
            psel = (phase < 4) ? first_ptrs[phase] : 3'($urandom_range(0, 7));
            base = sb.ip;
            r = $urandom_range(0, 99);
            if (r < 8)
                plen = '0;
            else if (r < 18)
                plen = 16'hFFFF;
            else if (r < 24 && base >= 0 && base <= 16'hFFFF)
                plen = 16'(base);  // stays halted for this phase
            else if (base + 40 > 16'hFFFF)
                plen = 16'hFFFF;
            else
                plen = 16'(base + $urandom_range(3, 40));

            if ($urandom_range(0, 3) == 0)
                write_cfg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                          16'($urandom));
            if ($urandom_range(0, 1)) begin
                write_cfg(CFG_PROGRAM_LENGTH, plen);
                write_cfg(CFG_POINTER_REGISTER, {13'($urandom), psel});
            end else begin
                write_cfg(CFG_POINTER_REGISTER,
                          $urandom_range(0, 1) ? {13'($urandom), psel} : {13'd0, psel});
                write_cfg(CFG_PROGRAM_LENGTH, plen);
            end

            n = $urandom_range(10, 60);
            idle_items = 0;
            for (int k = 0; k < n; k++) begin
                if (k != 0) pace();
                if (sb.running()) executed++;
                else idle_items++;
                push_instr(safe_instr());
                // a couple of ignored requests once halted is enough
                if (idle_items >= 2) break;
            end
            i_in_valid <= 1'b0;
            drain();
            phase++;
        end

        repeat (10) @(posedge i_clk);
        fails = sb.mismatches + sb.expected_steps.size();
        if (fails == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog
    initial begin
        #10ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
